// ===== sv/modbus_rtu_response_checker_assert.svh =====
// Assertion macros for the Modbus RTU response checker.
// Define ASSERT_OFF to compile them away; no other dependencies.
`ifndef MODBUS_RTU_RESPONSE_CHECKER_ASSERT_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define MBRC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MBRC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MBRC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define MBRC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== sv/mbrc_pkg.sv =====
// Shared types, constants and the CRC-16/MODBUS byte update for the
// Modbus RTU response checker. No dependencies.
package mbrc_pkg;

  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [7:0]  FUNC_READ         = 8'h03;
  localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
  localparam logic [8:0]  ECHO_FRAME_LEN    = 9'd8;
  localparam logic [8:0]  CRC_BYTES         = 9'd2;
  // address, function and byte count precede the data
  localparam logic [8:0]  HEADER_BYTES      = 9'd3;
  localparam logic [7:0]  MIN_BYTE_COUNT    = 8'd4;
  localparam logic [7:0]  MAX_BYTE_COUNT    = 8'd250;
  localparam logic [7:0]  LAST_VALUE_POS    = 8'd6;
  localparam logic [7:0]  SLAVE_ADDR_RESET  = 8'd1;

  // byte positions within a frame
  localparam logic [7:0]  POS_ADDR   = 8'd0;
  localparam logic [7:0]  POS_FUNC   = 8'd1;
  localparam logic [7:0]  POS_COUNT  = 8'd2;
  localparam logic [7:0]  POS_REG_HI = 8'd2;
  localparam logic [7:0]  POS_REG_LO = 8'd3;
  localparam logic [7:0]  POS_VAL_HI = 8'd4;

  // register index on the APB port
  localparam logic        REG_SLAVE_ADDRESS = 1'b0;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_ADDR = 3'd1,
    ST_FUNC = 3'd2,
    ST_CRC  = 3'd3,
    ST_ECHO = 3'd4
  } status_t;

  // One byte through CRC-16/MODBUS, reflected, LSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/modbus_rtu_response_checker.sv =====
// Modbus RTU response checker: top level, single module.
// Depends on mbrc_pkg and modbus_rtu_response_checker_assert.svh.
//
// Checks a Modbus RTU response one byte beat at a time and gives one status
// beat per frame. A beat with frame_start high opens a frame and samples
// mode (0 read holding registers, 1 write single echo), echo_register and
// echo_value. The address byte is checked against slave_address (APB
// register at byte address 0, reset 1), then the function code (0x03 or
// 0x06). Read replies take their length from the byte count (4 to 250
// accepted, else status 3); echoes are 8 bytes and bytes 2..5 must match the
// sampled register and value (status 4 on the first difference). The
// CRC-16/MODBUS trailer (low byte first) is checked last. Any mismatch ends
// the frame at once with its status; bytes outside a frame are dropped, and
// frame_start inside a frame abandons it silently. reg_value carries the
// big-endian value of data bytes 3..6 for a good read reply, else 0.
// Throughput is one byte beat per clock unless the sink stalls a status beat:
// an input register feeds a single pass of compare and byte-wide CRC logic
// that updates the frame state and the result register, so the final byte
// of a frame passes the input register, then the result register, which
// raises out_valid. in_stall rises only while the result register holds a
// beat that the sink is stalling and another byte waits in the input register.
`include "modbus_rtu_response_checker_assert.svh"

module modbus_rtu_response_checker
  import mbrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // received bytes
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        frame_start,
  input  logic        mode,
  input  logic [15:0] echo_register,
  input  logic [15:0] echo_value,
  // frame status
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] reg_value
);

  // ---------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------
  logic [7:0] slave_address;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign prdata  = (reg_sel == REG_SLAVE_ADDRESS) ? {24'h0, slave_address} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= SLAVE_ADDR_RESET;
    end else if (psel && penable && pwrite && pready && (reg_sel == REG_SLAVE_ADDRESS)) begin
      slave_address <= pwdata[7:0];
    end
  end

  // ---------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_start;
  logic        s1_mode;
  logic [15:0] s1_echo_reg;
  logic [15:0] s1_echo_val;
  logic        advance;
  logic        in_take;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte     <= rx_byte;
      s1_start    <= frame_start;
      s1_mode     <= mode;
      s1_echo_reg <= echo_register;
      s1_echo_val <= echo_value;
    end
  end

  // ---------------------------------------------------------------
  // Frame state
  // ---------------------------------------------------------------
  logic [7:0]  byte_position,     byte_position_next;
  logic [8:0]  frame_length,      frame_length_next;
  logic [15:0] running_crc,       running_crc_next;
  logic [31:0] value_shift,       value_shift_next;
  logic        frame_mode,        frame_mode_next;
  logic [15:0] expected_register, expected_register_next;
  logic [15:0] expected_value,    expected_value_next;
  logic        echo_ok,           echo_ok_next;
  logic        frame_active,      frame_active_next;

  logic        res_valid;
  status_t     res_status;
  logic [31:0] res_value;

  logic [15:0] crc_upd;
  logic [8:0]  pos_plus_crc;
  logic [7:0]  func_want;
  logic [7:0]  echo_want;
  logic        finish;

  always_comb begin
    // opening beat restarts the frame context
    if (s1_start) begin
      byte_position_next     = POS_ADDR;
      frame_length_next      = 9'd0;
      running_crc_next       = CRC_INIT;
      value_shift_next       = 32'h0;
      frame_mode_next        = s1_mode;
      expected_register_next = s1_echo_reg;
      expected_value_next    = s1_echo_val;
      echo_ok_next           = 1'b1;
      frame_active_next      = 1'b1;
    end else begin
      byte_position_next     = byte_position;
      frame_length_next      = frame_length;
      running_crc_next       = running_crc;
      value_shift_next       = value_shift;
      frame_mode_next        = frame_mode;
      expected_register_next = expected_register;
      expected_value_next    = expected_value;
      echo_ok_next           = echo_ok;
      frame_active_next      = frame_active;
    end

    crc_upd      = crc16_byte(running_crc_next, s1_byte);
    pos_plus_crc = {1'b0, byte_position_next} + CRC_BYTES;
    func_want    = frame_mode_next ? FUNC_WRITE_SINGLE : FUNC_READ;

    case (byte_position_next)
      POS_REG_HI: echo_want = expected_register_next[15:8];
      POS_REG_LO: echo_want = expected_register_next[7:0];
      POS_VAL_HI: echo_want = expected_value_next[15:8];
      default:    echo_want = expected_value_next[7:0];
    endcase

    finish     = 1'b0;
    res_status = ST_OK;
    res_value  = 32'h0;

    if (frame_active_next) begin
      priority if (byte_position_next == POS_ADDR) begin
        if (s1_byte != slave_address) begin
          finish     = 1'b1;
          res_status = ST_ADDR;
        end else begin
          running_crc_next = crc_upd;
        end
      end else if (byte_position_next == POS_FUNC) begin
        if (s1_byte != func_want) begin
          finish     = 1'b1;
          res_status = ST_FUNC;
        end else begin
          running_crc_next = crc_upd;
          if (frame_mode_next) begin
            frame_length_next = ECHO_FRAME_LEN;
          end
        end
      end else if (byte_position_next == POS_COUNT && !frame_mode_next) begin
        if (s1_byte < MIN_BYTE_COUNT || s1_byte > MAX_BYTE_COUNT) begin
          finish     = 1'b1;
          res_status = ST_CRC;
        end else begin
          running_crc_next  = crc_upd;
          frame_length_next = {1'b0, s1_byte} + HEADER_BYTES + CRC_BYTES;
        end
      end else if (pos_plus_crc < frame_length_next) begin
        // payload byte
        if (frame_mode_next) begin
          if (s1_byte != echo_want) begin
            echo_ok_next = 1'b0;
            finish       = 1'b1;
            res_status   = ST_ECHO;
          end
        end else if (byte_position_next <= LAST_VALUE_POS) begin
          value_shift_next = {value_shift_next[23:0], s1_byte};
        end
        if (!finish) begin
          running_crc_next = crc_upd;
        end
      end else if (pos_plus_crc == frame_length_next) begin
        if (s1_byte != running_crc_next[7:0]) begin
          finish     = 1'b1;
          res_status = ST_CRC;
        end
      end else begin
        // CRC high byte closes the frame
        finish = 1'b1;
        if (s1_byte != running_crc_next[15:8]) begin
          res_status = ST_CRC;
        end else if (frame_mode_next && !echo_ok_next) begin
          res_status = ST_ECHO;
        end else begin
          res_status = ST_OK;
          res_value  = frame_mode_next ? 32'h0 : value_shift_next;
        end
      end

      if (finish) begin
        frame_active_next = 1'b0;
      end else begin
        byte_position_next = byte_position_next + 8'd1;
      end
    end

    res_valid = finish;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= 8'd0;
      frame_length      <= 9'd0;
      running_crc       <= CRC_INIT;
      value_shift       <= 32'h0;
      frame_mode        <= 1'b0;
      expected_register <= 16'h0;
      expected_value    <= 16'h0;
      echo_ok           <= 1'b1;
      frame_active      <= 1'b0;
    end else if (advance) begin
      byte_position     <= byte_position_next;
      frame_length      <= frame_length_next;
      running_crc       <= running_crc_next;
      value_shift       <= value_shift_next;
      frame_mode        <= frame_mode_next;
      expected_register <= expected_register_next;
      expected_value    <= expected_value_next;
      echo_ok           <= echo_ok_next;
      frame_active      <= frame_active_next;
    end
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      status    <= res_status;
      reg_value <= res_value;
    end
  end

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  `MBRC_ASSERT_IMP(a_err_val, clk, rst, out_valid && status != ST_OK, reg_value == '0, "err value")
  `MBRC_ASSERT_NXT(a_res_load, clk, rst, advance && res_valid, out_valid, "result lost")
  `MBRC_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped")

endmodule
